// ----- sv/tcof_pkg.sv -----
// Package for the two-class oldest-first FIFO unit.
// Holds the request and status codes, the control state type and the default depth.
// No dependencies.
package tcof_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int TIME_W = 32;

    localparam logic [1:0] FUNC_ENQUEUE     = 2'd0;
    localparam logic [1:0] FUNC_DEQ_OLDEST  = 2'd1;
    localparam logic [1:0] FUNC_DEQ_CLASS0  = 2'd2;
    localparam logic [1:0] FUNC_DEQ_CLASS1  = 2'd3;

    localparam logic [1:0] STATUS_ENQUEUED = 2'd0;
    localparam logic [1:0] STATUS_SERVED   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// ----- sv/two_class_oldest_first_fifo_unit.sv -----
// Two-class oldest-first FIFO unit: two timestamp queues in synchronous RAMs.
// Depends on tcof_pkg.
//
// channel | valid     | stall     | word
// --------+-----------+-----------+------------------------------------------
// request | req_valid | req_stall | func, item_class, arrival_time
// result  | rsp_valid | rsp_stall | status, served_class, served_time
//
// Each request passes through an accept step, during which both RAMs read
// their head entries, and an execute step that compares the registered heads,
// pushes or pops and loads the result register; the registered RAM read forces the split.
// Execute waits while the result register is full and stalled.
// Reset (rst_n low, asynchronous) empties both queues; no clearing pass.
module two_class_oldest_first_fifo_unit
    import tcof_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        func,
    input  logic              item_class,
    input  logic [TIME_W-1:0] arrival_time,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [1:0]        status,
    output logic              served_class,
    output logic [TIME_W-1:0] served_time
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    logic [TIME_W-1:0] mem0 [QUEUE_DEPTH];
    logic [TIME_W-1:0] mem1 [QUEUE_DEPTH];
    logic [TIME_W-1:0] rd0_reg, rd1_reg;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head0_reg, head0_next, tail0_reg, tail0_next;
    logic [PTR_W-1:0]  head1_reg, head1_next, tail1_reg, tail1_next;
    logic [CNT_W-1:0]  count0_reg, count0_next, count1_reg, count1_next;

    logic [1:0]        func_reg;
    logic              class_reg;
    logic [TIME_W-1:0] time_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [1:0]        status_reg, status_next;
    logic              served_class_reg, served_class_next;
    logic [TIME_W-1:0] served_time_reg, served_time_next;

    logic              accept, fire;
    logic              push0, push1, pop0, pop1;
    logic              has0, has1, older0;

    assign req_stall    = (state_reg != S_IDLE);
    assign accept       = req_valid && !req_stall;
    assign fire         = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign served_class = served_class_reg;
    assign served_time  = served_time_reg;

    // RAMs: read at head every cycle, write at tail on push
    always_ff @(posedge clk)
    begin
        rd0_reg <= mem0[head0_reg];
        if (push0)
        begin
            mem0[tail0_reg] <= time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd1_reg <= mem1[head1_reg];
        if (push1)
        begin
            mem1[tail1_reg] <= time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            class_reg <= item_class;
            time_reg  <= arrival_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head0_reg     <= '0;
            tail0_reg     <= '0;
            count0_reg    <= '0;
            head1_reg     <= '0;
            tail1_reg     <= '0;
            count1_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head0_reg     <= head0_next;
            tail0_reg     <= tail0_next;
            count0_reg    <= count0_next;
            head1_reg     <= head1_next;
            tail1_reg     <= tail1_next;
            count1_reg    <= count1_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        served_class_reg <= served_class_next;
        served_time_reg  <= served_time_next;
    end

    always_comb
    begin
        has0   = (count0_reg != '0);
        has1   = (count1_reg != '0);
        older0 = (rd0_reg < rd1_reg);

        push0 = 1'b0;
        push1 = 1'b0;
        pop0  = 1'b0;
        pop1  = 1'b0;

        state_next        = state_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        status_next       = status_reg;
        served_class_next = served_class_reg;
        served_time_next  = served_time_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next        = S_IDLE;
                    rsp_valid_next    = 1'b1;
                    served_class_next = 1'b0;
                    served_time_next  = '0;
                    case (func_reg)
                        FUNC_ENQUEUE:
                        begin
                            if (class_reg)
                            begin
                                push1 = (count1_reg != FULL_COUNT);
                            end
                            else
                            begin
                                push0 = (count0_reg != FULL_COUNT);
                            end
                        end
                        FUNC_DEQ_OLDEST:
                        begin
                            if (has0 && (!has1 || older0))
                            begin
                                pop0 = 1'b1;
                            end
                            else
                            begin
                                pop1 = has1;
                            end
                        end
                        FUNC_DEQ_CLASS0:
                        begin
                            pop0 = has0;
                        end
                        FUNC_DEQ_CLASS1:
                        begin
                            pop1 = has1;
                        end
                        default:
                        begin
                            pop0 = 1'b0;
                        end
                    endcase

                    if (func_reg == FUNC_ENQUEUE)
                    begin
                        status_next = (push0 || push1) ? STATUS_ENQUEUED : STATUS_FULL;
                    end
                    else if (pop0)
                    begin
                        status_next       = STATUS_SERVED;
                        served_class_next = 1'b0;
                        served_time_next  = rd0_reg;
                    end
                    else if (pop1)
                    begin
                        status_next       = STATUS_SERVED;
                        served_class_next = 1'b1;
                        served_time_next  = rd1_reg;
                    end
                    else
                    begin
                        status_next = STATUS_EMPTY;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        head0_next  = head0_reg;
        tail0_next  = tail0_reg;
        count0_next = count0_reg;
        head1_next  = head1_reg;
        tail1_next  = tail1_reg;
        count1_next = count1_reg;

        if (push0)
        begin
            tail0_next  = (tail0_reg == LAST_PTR) ? '0 : tail0_reg + 1'b1;
            count0_next = count0_reg + 1'b1;
        end
        if (pop0)
        begin
            head0_next  = (head0_reg == LAST_PTR) ? '0 : head0_reg + 1'b1;
            count0_next = count0_reg - 1'b1;
        end
        if (push1)
        begin
            tail1_next  = (tail1_reg == LAST_PTR) ? '0 : tail1_reg + 1'b1;
            count1_next = count1_reg + 1'b1;
        end
        if (pop1)
        begin
            head1_next  = (head1_reg == LAST_PTR) ? '0 : head1_reg + 1'b1;
            count1_next = count1_reg - 1'b1;
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench for two_class_oldest_first_fifo_unit: directed and random request words
// checked against a queue-based predictor, with random gaps and stalls on both channels.
// Depends on tcof_pkg and the unit's RTL.
module tb;
    import tcof_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]        status;
        logic              served_class;
        logic [TIME_W-1:0] served_time;
    } service_result_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic [1:0]        func;
    logic              item_class;
    logic [TIME_W-1:0] arrival_time;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [1:0]        status;
    logic              served_class;
    logic [TIME_W-1:0] served_time;

    logic [TIME_W-1:0] class0_fifo[$];
    logic [TIME_W-1:0] class1_fifo[$];
    service_result_t   pending_results[$];
    int                errors;
    int                quiet_cycles;
    bit                idle_on;
    logic [TIME_W-1:0] stamp_clock;

    two_class_oldest_first_fifo_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .item_class   (item_class),
        .arrival_time (arrival_time),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .served_class (served_class),
        .served_time  (served_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic service_result_t predict_service(input logic [1:0] f, input logic c,
                                                        input logic [TIME_W-1:0] t);
        service_result_t r;
        bit have0;
        bit have1;
        bit found;
        bit pick1;
        r = '0;
        have0 = class0_fifo.size() != 0;
        have1 = class1_fifo.size() != 0;
        found = 1'b0;
        pick1 = 1'b0;
        if (f == FUNC_ENQUEUE)
        begin
            r.status = STATUS_ENQUEUED;
            if (c)
            begin
                if (class1_fifo.size() >= DEFAULT_QUEUE_DEPTH)
                    r.status = STATUS_FULL;
                else
                    class1_fifo.push_back(t);
            end
            else
            begin
                if (class0_fifo.size() >= DEFAULT_QUEUE_DEPTH)
                    r.status = STATUS_FULL;
                else
                    class0_fifo.push_back(t);
            end
            return r;
        end
        case (f)
            FUNC_DEQ_OLDEST:
            begin
                found = have0 || have1;
                // ties go to class 1
                pick1 = !have0 || (have1 && !(class0_fifo[0] < class1_fifo[0]));
            end
            FUNC_DEQ_CLASS0:
            begin
                found = have0;
                pick1 = 1'b0;
            end
            default:
            begin
                found = have1;
                pick1 = 1'b1;
            end
        endcase
        if (!found)
            r.status = STATUS_EMPTY;
        else
        begin
            r.status = STATUS_SERVED;
            r.served_class = pick1;
            r.served_time = pick1 ? class1_fifo.pop_front() : class0_fifo.pop_front();
        end
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            2, 3: return TIME_W'($urandom_range(3));
            4: return TIME_W'($urandom);
            default:
            begin
                stamp_clock = stamp_clock + TIME_W'($urandom_range(40));
                return stamp_clock;
            end
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] f, input logic c, input logic [TIME_W-1:0] t);
        if (idle_on && $urandom_range(99) < 24)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while (idle_on && $urandom_range(99) < 24);
        end
        req_valid    <= 1'b1;
        func         <= f;
        item_class   <= c;
        arrival_time <= t;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(predict_service(f, c, t));
        @(negedge clk);
    endtask

    task automatic test_empty_requests();
        send_word(FUNC_DEQ_OLDEST, 1'b1, '1);
        send_word(FUNC_DEQ_CLASS0, 1'b1, '1);
        send_word(FUNC_DEQ_CLASS1, 1'b0, '0);
    endtask

    task automatic test_oldest_first();
        send_word(FUNC_ENQUEUE, 1'b0, 32'd5);
        send_word(FUNC_ENQUEUE, 1'b1, 32'd5);
        send_word(FUNC_DEQ_OLDEST, 1'b0, '0);
        send_word(FUNC_ENQUEUE, 1'b1, '1);
        send_word(FUNC_DEQ_OLDEST, 1'b1, '1);
        send_word(FUNC_DEQ_CLASS1, 1'b0, '0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < DEFAULT_QUEUE_DEPTH; i++)
            send_word(FUNC_ENQUEUE, 1'b0, 32'h8000_0000 + TIME_W'(i));
        send_word(FUNC_ENQUEUE, 1'b0, '1);
    endtask

    task automatic test_random_traffic(input int n, input int enq_pct);
        logic [1:0] f;
        repeat (n)
        begin
            if ($urandom_range(99) < enq_pct)
                f = FUNC_ENQUEUE;
            else
                f = 2'($urandom_range(3, 1));
            send_word(f, 1'($urandom), next_stamp());
        end
    endtask

    task automatic test_back_to_back(input int n);
        idle_on = 1'b0;
        test_random_traffic(n, 50);
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        func         = FUNC_ENQUEUE;
        item_class   = 1'b0;
        arrival_time = '0;
        errors       = 0;
        idle_on      = 1'b1;
        stamp_clock  = TIME_W'($urandom);
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_empty_requests();
        test_oldest_first();
        test_full_queue();
        test_random_traffic(200, 25);
        test_random_traffic(200, 75);
        test_random_traffic(300, 50);
        test_back_to_back(200);
        test_random_traffic(75, 80);
        test_random_traffic(75, 20);

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS two_class_oldest_first_fifo_unit");
        else
            $display("FAIL two_class_oldest_first_fifo_unit");
        $finish;
    end

    initial
    begin
        service_result_t want;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with none expected: status %0d", status);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (served_class !== want.served_class)
                    begin
                        $error("served_class: expected %0d, got %0d",
                               want.served_class, served_class);
                        errors++;
                    end
                    if (served_time !== want.served_time)
                    begin
                        $error("served_time: expected %h, got %h",
                               want.served_time, served_time);
                        errors++;
                    end
                end
            end
            @(negedge clk);
            rsp_stall <= idle_on && ($urandom_range(99) < 24);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL two_class_oldest_first_fifo_unit");
        $finish;
    end

endmodule
